/* rtl/kprt_pkg.sv */
// Shared types, constants and helpers for the key press/repeat/release tracker.
// No dependencies; imported by every module of the block.
package kprt_pkg;

  localparam int NUM_KEYS   = 16;
  localparam int KEY_SLOTS  = 16;
  localparam int TRACK_KEYS = (NUM_KEYS < KEY_SLOTS) ? NUM_KEYS : KEY_SLOTS;
  localparam int KEY_W      = 4;
  localparam int MASK_W     = 16;
  localparam int TIME_W     = 32;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_W-1:0] RESET_DELAY    = 16'd200;
  localparam logic [CFG_W-1:0] RESET_INTERVAL = 16'd60;

  localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 1'b1;

  typedef enum logic [1:0] {
    EV_PRESS   = 2'd0,
    EV_REPEAT  = 2'd1,
    EV_RELEASE = 2'd2
  } kprt_event_t;

  // Controller to datapath.
  typedef struct packed {
    logic             load;    // input transfer this cycle
    logic             commit;  // apply the current key's update
    logic             flush;   // move held event out as the last of the poll
    logic [KEY_W-1:0] key;     // key under evaluation
    logic [KEY_W-1:0] rd_key;  // deadline entry to fetch for next cycle
  } kprt_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic emit;        // current key causes an event
    logic pend_valid;  // one event held back, waiting for its last flag
    logic out_free;    // output register can take an event this cycle
  } kprt_sts_t;

  // Strictly past: wrapped difference nonzero and positive as signed.
  function automatic logic time_past(input logic [TIME_W-1:0] now,
                                     input logic [TIME_W-1:0] deadline);
    logic [TIME_W-1:0] d;
    d = now - deadline;
    return (d != '0) && !d[TIME_W-1];
  endfunction

endpackage

/* rtl/kprt_datapath.sv */
// Datapath: configuration, poll registers, deadline memory, held-key mask,
// held-back event and output register. Depends on kprt_pkg.
module kprt_datapath
  import kprt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic [MASK_W-1:0]    in_key_mask,
  input  logic [TIME_W-1:0]    in_time_now,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [KEY_W-1:0]     out_key_index,
  output logic [1:0]           out_event_kind,
  output logic                 out_last_event,
  input  kprt_cmd_t            cmd,
  output kprt_sts_t            sts
);

  logic [CFG_W-1:0]    delay_r, interval_r;
  logic [MASK_W-1:0]   mask_r;
  logic [TIME_W-1:0]   now_r, press_base_r, rep_base_r;
  logic [MASK_W-1:0]   held_r;

  // Each entry: {press deadline, repeat deadline}.
  logic [2*TIME_W-1:0] dl_mem [KEY_SLOTS];
  logic [2*TIME_W-1:0] rdata_r;
  logic [TIME_W-1:0]   press_dl, rep_dl;

  logic                pend_valid_r;
  logic [KEY_W-1:0]    pend_key_r;
  logic [1:0]          pend_kind_r;

  logic                out_valid_r, out_last_r;
  logic [KEY_W-1:0]    out_key_r;
  logic [1:0]          out_kind_r;

  logic                cur, prev, emit, wr_en;
  logic [1:0]          kind;
  logic [2*TIME_W-1:0] wdata;
  logic                out_free, push;

  assign press_dl = rdata_r[2*TIME_W-1:TIME_W];
  assign rep_dl   = rdata_r[TIME_W-1:0];
  assign cur      = mask_r[cmd.key];
  assign prev     = held_r[cmd.key];

  always_comb begin
    emit  = 1'b0;
    wr_en = 1'b0;
    kind  = EV_PRESS;
    wdata = rdata_r;
    if (cur && !prev) begin
      emit  = 1'b1;
      wr_en = 1'b1;
      kind  = EV_PRESS;
      wdata = {press_base_r, press_base_r + TIME_W'(interval_r)};
    end else if (cur && prev) begin
      if (time_past(now_r, rep_dl) && time_past(now_r, press_dl)) begin
        emit  = 1'b1;
        wr_en = 1'b1;
        kind  = EV_REPEAT;
        wdata = {press_dl, rep_base_r};
      end
    end else if (!cur && prev) begin
      emit = 1'b1;
      kind = EV_RELEASE;
    end
  end

  assign out_free = !out_valid_r || out_ready;
  // A newer event pushes the held one out with last cleared.
  assign push     = (cmd.commit && emit && pend_valid_r) || cmd.flush;

  assign sts.emit       = emit;
  assign sts.pend_valid = pend_valid_r;
  assign sts.out_free   = out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r    <= RESET_DELAY;
      interval_r <= RESET_INTERVAL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DELAY:    delay_r    <= cfg_wdata;
        REG_INTERVAL: interval_r <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  // Poll registers; deadline bases are formed at the transfer.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mask_r       <= in_key_mask;
      now_r        <= in_time_now;
      press_base_r <= in_time_now + TIME_W'(delay_r);
      rep_base_r   <= in_time_now + TIME_W'(interval_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      dl_mem[cmd.key] <= wdata;
    end
    rdata_r <= dl_mem[cmd.rd_key];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (cmd.commit && emit) begin
      held_r[cmd.key] <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else if (cmd.commit && emit) begin
      pend_valid_r <= 1'b1;
    end else if (cmd.flush) begin
      pend_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && emit) begin
      pend_key_r  <= cmd.key;
      pend_kind_r <= kind;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_key_r  <= pend_key_r;
      out_kind_r <= pend_kind_r;
      out_last_r <= cmd.flush;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_key_index  = out_key_r;
  assign out_event_kind = out_kind_r;
  assign out_last_event = out_last_r;

endmodule

/* rtl/kprt_controller.sv */
// Controller: walks the tracked keys once per poll and sequences the datapath.
// Depends on kprt_pkg.
module kprt_controller
  import kprt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output kprt_cmd_t cmd,
  input  kprt_sts_t sts
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_FLUSH
  } state_t;

  state_t           state_r, state_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic             stall, last_key;

  assign last_key = (key_r == KEY_W'(TRACK_KEYS - 1));
  // Both the held event and the new one need a slot: wait for the output.
  assign stall    = sts.emit && sts.pend_valid && !sts.out_free;

  always_comb begin
    state_nxt  = state_r;
    key_nxt    = key_r;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.key    = key_r;
    cmd.rd_key = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid) begin
          state_nxt = ST_EVAL;
          key_nxt   = '0;
        end
      end
      ST_EVAL: begin
        cmd.commit = !stall;
        cmd.rd_key = stall ? key_r : key_r + KEY_W'(1);
        if (!stall) begin
          if (last_key) begin
            state_nxt = ST_FLUSH;
          end else begin
            key_nxt = key_r + KEY_W'(1);
          end
        end
      end
      ST_FLUSH: begin
        if (!sts.pend_valid) begin
          state_nxt = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      key_r   <= '0;
    end else begin
      state_r <= state_nxt;
      key_r   <= key_nxt;
    end
  end

endmodule

/* rtl/key_press_repeat_release_tracker_unit.sv */
// Top level of the key press/repeat/release tracker: controller plus datapath.
// Depends on kprt_pkg, kprt_controller and kprt_datapath.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    in_key_mask, in_time_now
//   out      output     out_valid/out_ready  out_key_index, out_event_kind,
//                                            out_last_event
//   cfg      input      cfg_we               cfg_index, cfg_wdata
//
// A poll runs through the transfer, a walk of the keys through the deadline memory,
// and a final step that releases the final event.
// One event is held back until the next is found, so its last flag is known.
// The walk holds on a key with an event while one is already held back and the
// output register is full; the final release also waits for room there.
// Synchronous active-low reset clears the held-key mask, event flags and FSM state;
// the deadline memory needs no clearing since a key is pressed before it is read.
module key_press_repeat_release_tracker_unit
  import kprt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [MASK_W-1:0]    in_key_mask,
  input  logic [TIME_W-1:0]    in_time_now,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [KEY_W-1:0]     out_key_index,
  output logic [1:0]           out_event_kind,
  output logic                 out_last_event
);

  kprt_cmd_t cmd;
  kprt_sts_t sts;

  kprt_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  kprt_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_key_mask    (in_key_mask),
    .in_time_now    (in_time_now),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_key_index  (out_key_index),
    .out_event_kind (out_event_kind),
    .out_last_event (out_last_event),
    .cmd            (cmd),
    .sts            (sts)
  );

`ifndef SYNTHESIS
  // A new poll never starts with an event still held from the previous one.
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !sts.pend_valid)
    else $error("poll accepted while an event is still held");

  // Pushing a held event out requires room in the output register.
  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && sts.emit && sts.pend_valid) |-> sts.out_free)
    else $error("event pushed into a full output register");

  a_flush_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |-> (sts.pend_valid && sts.out_free))
    else $error("flush without a held event or output room");

  // Every final event is followed by an idle controller.
  a_flush_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |=> in_ready)
    else $error("controller not idle after final event");
`endif

endmodule
